// ===== rtl/core/lpsp_pkg.sv =====
package lpsp_pkg;

  localparam int unsigned KindW = 2;
  localparam int unsigned ErrW  = 2;
  localparam int unsigned CfgW  = 32;

  // result kinds
  localparam logic [KindW-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [ErrW-1:0] ERR_BAD_CHAR        = 2'd0;
  localparam logic [ErrW-1:0] ERR_TOO_MANY_DIGITS = 2'd1;
  localparam logic [ErrW-1:0] ERR_TOO_LONG        = 2'd2;
  localparam logic [ErrW-1:0] ERR_ENDED_EARLY     = 2'd3;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [CfgW-1:0] MAX_LENGTH_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_mark;
  } item_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [7:0]       payload_byte;
    logic             last;
    logic [ErrW-1:0]  error_code;
  } result_t;

endpackage

// ===== rtl/core/lpsp_in_reg.sv =====
module lpsp_in_reg
  import lpsp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/core/lpsp_step.sv =====
module lpsp_step
  import lpsp_pkg::*;
#(
  parameter int unsigned MAX_DIGITS  = 21,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_max_length_i,
  input  logic            take_i,
  input  item_t           item_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CmpW = (LENGTH_BITS > CfgW) ? LENGTH_BITS : CfgW;
  localparam int unsigned ProdW = LENGTH_BITS + 4;

  logic [CfgW-1:0]        max_length_q;
  logic                   in_payload_q, in_payload_d;
  logic [CntW-1:0]        digit_count_q, digit_count_d;
  logic [LENGTH_BITS-1:0] length_accum_q, length_accum_d;
  logic                   length_overflow_q, length_overflow_d;
  logic [LENGTH_BITS-1:0] bytes_remaining_q, bytes_remaining_d;

  logic             is_digit;
  logic [3:0]       digit;
  logic [ProdW-1:0] accum_ext;
  logic [ProdW-1:0] prod;
  logic             too_long;
  logic             fin;

  assign is_digit  = (item_i.data_byte >= CHAR_ZERO) && (item_i.data_byte <= CHAR_NINE);
  assign digit     = 4'(item_i.data_byte - CHAR_ZERO);
  assign accum_ext = ProdW'(length_accum_q);
  // 10*a + d, carried four bits wider so a wrap shows in the top bits
  assign prod      = (accum_ext << 3) + (accum_ext << 1) + ProdW'(digit);
  assign too_long  = length_overflow_q ||
                     (CmpW'(length_accum_q) > CmpW'(max_length_q));
  assign fin       = bytes_remaining_q <= LENGTH_BITS'(1);

  always_comb begin
    in_payload_d      = in_payload_q;
    digit_count_d     = digit_count_q;
    length_accum_d    = length_accum_q;
    length_overflow_d = length_overflow_q;
    bytes_remaining_d = bytes_remaining_q;
    res_valid_o       = 1'b0;
    res_o             = '0;
    if (take_i) begin
      if (item_i.end_mark) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_ENDED_EARLY;
      end else if (in_payload_q) begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_BYTE;
        res_o.payload_byte = item_i.data_byte;
        res_o.last         = fin;
        bytes_remaining_d  = bytes_remaining_q - LENGTH_BITS'(1);
      end else if (item_i.data_byte == CHAR_COLON) begin
        if (too_long) begin
          res_valid_o      = 1'b1;
          res_o.kind       = KIND_ERROR;
          res_o.error_code = ERR_TOO_LONG;
        end else if (length_accum_q == '0) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_EMPTY;
          res_o.last  = 1'b1;
        end else begin
          in_payload_d      = 1'b1;
          bytes_remaining_d = length_accum_q;
        end
      end else if (!is_digit) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_BAD_CHAR;
      end else if (digit_count_q >= CntW'(MAX_DIGITS)) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_TOO_MANY_DIGITS;
      end else begin
        digit_count_d = digit_count_q + CntW'(1);
        if (!length_overflow_q) begin
          if (prod[ProdW-1:LENGTH_BITS] != '0) begin
            length_overflow_d = 1'b1;
          end else begin
            length_accum_d = prod[LENGTH_BITS-1:0];
          end
        end
      end

      // a result or a colon outside a payload restarts the length digits
      if (res_valid_o || (!in_payload_q && item_i.data_byte == CHAR_COLON)) begin
        digit_count_d     = '0;
        length_accum_d    = '0;
        length_overflow_d = 1'b0;
      end
      if (res_valid_o && !(in_payload_q && !item_i.end_mark && !fin)) begin
        in_payload_d      = 1'b0;
        bytes_remaining_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q      <= MAX_LENGTH_RESET;
      in_payload_q      <= 1'b0;
      digit_count_q     <= '0;
      length_accum_q    <= '0;
      length_overflow_q <= 1'b0;
      bytes_remaining_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_length_q <= cfg_max_length_i;
      end
      in_payload_q      <= in_payload_d;
      digit_count_q     <= digit_count_d;
      length_accum_q    <= length_accum_d;
      length_overflow_q <= length_overflow_d;
      bytes_remaining_q <= bytes_remaining_d;
    end
  end

endmodule

// ===== rtl/core/lpsp_out_reg.sv =====
module lpsp_out_reg
  import lpsp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  output logic    can_load_o,
  input  logic    load_i,
  input  result_t res_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign can_load_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/core/length_prefixed_string_parser.sv =====
// Bencode byte-string parser: takes one stream word per cycle (decimal length,
// colon, payload) and returns at most one result word per input word: each
// payload byte with last set on the final one, an empty-string result for a
// zero length, or an error (bad character, too many digits, length above
// max_length, end mark on any word). Sustained rate is one word per clock while
// out_ready_i holds; words pass the input register, then the result register,
// with all parsing done by the single step between them. Ready propagates
// combinationally from out_ready_i back to in_ready_o. max_length resets to
// all ones; the user must write it only while the block is idle (unenforced).
module length_prefixed_string_parser
  import lpsp_pkg::*;
#(
  parameter int unsigned MAX_DIGITS  = 21,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CfgW-1:0]  cfg_max_length_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             end_mark_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KindW-1:0] kind_o,
  output logic [7:0]       payload_byte_o,
  output logic             last_o,
  output logic [ErrW-1:0]  error_code_o
);

  item_t   in_item, reg_item;
  logic    reg_valid;
  logic    can_load;
  logic    take;
  logic    res_valid;
  result_t res, out_res;

  assign cfg_ready_o = 1'b1;
  assign in_item     = '{data_byte: data_byte_i, end_mark: end_mark_i};
  assign take        = reg_valid && can_load;

  lpsp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .valid_o    (reg_valid),
    .take_i     (take),
    .item_o     (reg_item)
  );

  lpsp_step #(
    .MAX_DIGITS  (MAX_DIGITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_max_length_i (cfg_max_length_i),
    .take_i           (take),
    .item_i           (reg_item),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  lpsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .can_load_o  (can_load),
    .load_i      (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign payload_byte_o = out_res.payload_byte;
  assign last_o         = out_res.last;
  assign error_code_o   = out_res.error_code;

endmodule
